### hw/rtl/assert_macros.svh
// Assertion macros used by the checker file crd_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, masked while reset is asserted
`define CRD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent check, live through reset as well
`define CRD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/crd_pkg.sv
// Package: types and codes of the compact record decoder
package crd_pkg;

  localparam int VALUE_BYTES_DEF = 4;
  localparam int BYTE_W          = 8;
  localparam int KIND_W          = 3;
  localparam int VALUE_W         = 32;

  localparam logic [KIND_W-1:0] KIND_COUNT     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_STR_START = 3'd1;
  localparam logic [KIND_W-1:0] KIND_STR_CHAR  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SINT      = 3'd3;
  localparam logic [KIND_W-1:0] KIND_UINT      = 3'd4;

  localparam logic [1:0] PH_COUNT   = 2'd0;
  localparam logic [1:0] PH_HEADER  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;

  localparam logic [1:0] FT_STRING   = 2'd0;
  localparam logic [1:0] FT_SIGNED   = 2'd1;
  localparam logic [1:0] FT_UNSIGNED = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic               field_done;
    logic               record_done;
    logic               stream_done;
  } res_t;

  typedef struct packed {
    logic has_result;
    res_t res;
  } step_t;

endpackage

### hw/rtl/crd_ifs.sv
// Channel interfaces: byte input and decoded result output
interface crd_byte_if;
  import crd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface crd_result_if;
  import crd_pkg::*;
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [VALUE_W-1:0] value;
  logic               field_done;
  logic               record_done;
  logic               stream_done;
  modport source (output valid, output kind, output value, output field_done,
                  output record_done, output stream_done, input ready);
  modport sink   (input valid, input kind, input value, input field_done,
                  input record_done, input stream_done, output ready);
endinterface

### hw/rtl/crd_decode.sv
// Decoder state and single-pass next-state and result logic
module crd_decode #(
  parameter int VALUE_BYTES = crd_pkg::VALUE_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       fire,
  input  logic [crd_pkg::BYTE_W-1:0] in_byte,
  output crd_pkg::step_t             step
);
  import crd_pkg::*;

  localparam int ACC_W = 8 * VALUE_BYTES;

  logic [1:0]       phase_r, phase_nxt;
  logic [7:0]       records_left_r, records_left_nxt;
  logic [5:0]       bytes_left_r, bytes_left_nxt;
  logic [1:0]       field_type_r, field_type_nxt;
  logic             field_last_r, field_last_nxt;
  logic [4:0]       int_len_r, int_len_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;

  logic [ACC_W+7:0]   acc_wide;
  logic [ACC_W-1:0]   acc_sh;
  logic [63:0]        acc64;
  logic               len_hit;
  logic               sgn;
  logic               sext;
  logic [VALUE_W-1:0] int_val;
  logic               finish;
  logic               last_now;
  logic [7:0]         rec_dec;
  logic [5:0]         bl_dec;

  assign acc_wide = {acc_r, in_byte};
  assign acc_sh   = acc_wide[ACC_W-1:0];
  assign acc64    = 64'(acc_sh);
  assign rec_dec  = records_left_r - 8'd1;
  assign bl_dec   = bytes_left_r - 6'd1;

  // sign extension of short signed integers from their top byte
  always_comb begin
    len_hit = 1'b0;
    sgn     = 1'b0;
    for (int k = 0; k < VALUE_BYTES - 1; k++) begin
      if (int_len_r == 5'(k + 1)) begin
        len_hit = 1'b1;
        sgn     = acc64[8*k+7];
      end
    end
    sext    = (field_type_r == FT_SIGNED) && len_hit && sgn;
    int_val = acc64[VALUE_W-1:0];
    for (int j = 0; j < VALUE_W / 8; j++) begin
      if (sext && (5'(j) >= int_len_r)) int_val[8*j +: 8] = 8'hff;
    end
  end

  always_comb begin
    phase_nxt        = phase_r;
    records_left_nxt = records_left_r;
    bytes_left_nxt   = bytes_left_r;
    field_type_nxt   = field_type_r;
    field_last_nxt   = field_last_r;
    int_len_nxt      = int_len_r;
    acc_nxt          = acc_r;
    step             = '0;
    finish           = 1'b0;
    last_now         = (phase_r == PH_HEADER) ? in_byte[7] : field_last_r;

    unique case (phase_r)
      PH_HEADER: begin
        field_last_nxt = in_byte[7];
        if (in_byte[6]) begin
          field_type_nxt       = FT_STRING;
          step.has_result      = 1'b1;
          step.res.kind        = KIND_STR_START;
          step.res.value       = VALUE_W'(in_byte[5:0]);
          if (in_byte[5:0] == 6'd0) begin
            finish = 1'b1;
          end else begin
            bytes_left_nxt = in_byte[5:0];
            phase_nxt      = PH_PAYLOAD;
          end
        end else begin
          field_type_nxt = in_byte[5] ? FT_SIGNED : FT_UNSIGNED;
          int_len_nxt    = in_byte[4:0];
          acc_nxt        = '0;
          if (in_byte[4:0] == 5'd0) begin
            step.has_result = 1'b1;
            step.res.kind   = in_byte[5] ? KIND_SINT : KIND_UINT;
            step.res.value  = '0;
            finish          = 1'b1;
          end else begin
            bytes_left_nxt = {1'b0, in_byte[4:0]};
            phase_nxt      = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        bytes_left_nxt = bl_dec;
        if (field_type_r == FT_STRING) begin
          step.has_result = 1'b1;
          step.res.kind   = KIND_STR_CHAR;
          step.res.value  = VALUE_W'(in_byte);
          finish          = (bl_dec == 6'd0);
        end else begin
          acc_nxt = acc_sh;
          if (bl_dec == 6'd0) begin
            step.has_result = 1'b1;
            step.res.kind   = (field_type_r == FT_SIGNED) ? KIND_SINT : KIND_UINT;
            step.res.value  = int_val;
            finish          = 1'b1;
          end
        end
      end
      default: begin
        records_left_nxt = in_byte;
        step.has_result  = 1'b1;
        step.res.kind    = KIND_COUNT;
        step.res.value   = VALUE_W'(in_byte);
        if (in_byte == 8'd0) begin
          step.res.stream_done = 1'b1;
          phase_nxt            = PH_COUNT;
        end else begin
          phase_nxt = PH_HEADER;
        end
      end
    endcase

    if (finish) begin
      step.res.field_done = 1'b1;
      phase_nxt           = PH_HEADER;
      if (last_now) begin
        step.res.record_done = 1'b1;
        records_left_nxt     = rec_dec;
        if (rec_dec == 8'd0) begin
          step.res.stream_done = 1'b1;
          phase_nxt            = PH_COUNT;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_COUNT;
      records_left_r <= '0;
      bytes_left_r   <= '0;
      field_type_r   <= FT_STRING;
      field_last_r   <= 1'b0;
      int_len_r      <= '0;
      acc_r          <= '0;
    end else if (fire) begin
      phase_r        <= phase_nxt;
      records_left_r <= records_left_nxt;
      bytes_left_r   <= bytes_left_nxt;
      field_type_r   <= field_type_nxt;
      field_last_r   <= field_last_nxt;
      int_len_r      <= int_len_nxt;
      acc_r          <= acc_nxt;
    end
  end

endmodule

### hw/rtl/crd_out_reg.sv
// Result register: holds one result until the sink takes the transfer
module crd_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  crd_pkg::res_t  res,
  input  logic           out_ready,
  output logic           room,
  output logic           out_valid,
  output crd_pkg::res_t  out_res
);
  import crd_pkg::*;

  logic valid_r;
  res_t data_r;

  assign room      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (room) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (room && load) begin
      data_r <= res;
    end
  end

endmodule

### hw/rtl/compact_record_decoder.sv
// Top level of the compact record decoder
//
// in_chan  : one stream byte per transfer (valid/ready).
// out_chan : decoded results (kind, value, field/record/stream done flags).
// A count byte opens a stream; each field then has a header byte followed by
// string characters or big-endian integer bytes. Count, string start, each
// character and each finished integer give one result; integer headers of
// non-zero length and non-final integer bytes give none.
// Latency: a result appears on out_chan the cycle after its byte transfers.
// Throughput: one byte per cycle while out_chan.ready is high, set by the single
// state register pass and the one-entry result register.
// in_chan.ready is high while the result register is empty or being emptied,
// so a stalled sink holds the current result and stops input in the same cycle.
// Reset (rst_n low, synchronous) empties the result register and returns the
// decoder to waiting for a count byte.
module compact_record_decoder #(
  parameter int VALUE_BYTES = crd_pkg::VALUE_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  crd_byte_if.sink     in_chan,
  crd_result_if.source out_chan
);
  import crd_pkg::*;

  logic  room;
  logic  fire;
  step_t step;
  res_t  out_res;
  logic  out_valid;

  assign in_chan.ready = room;
  assign fire          = in_chan.valid && room;

  crd_decode #(
    .VALUE_BYTES (VALUE_BYTES)
  ) u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .in_byte (in_chan.in_byte),
    .step    (step)
  );

  crd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire && step.has_result),
    .res       (step.res),
    .out_ready (out_chan.ready),
    .room      (room),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_chan.valid       = out_valid;
  assign out_chan.kind        = out_res.kind;
  assign out_chan.value       = out_res.value;
  assign out_chan.field_done  = out_res.field_done;
  assign out_chan.record_done = out_res.record_done;
  assign out_chan.stream_done = out_res.stream_done;

endmodule

### hw/rtl/crd_checker.sv
// Port-level checks of the compact record decoder, bound to the top level
`include "assert_macros.svh"

module crd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [crd_pkg::KIND_W-1:0]  out_kind,
  input logic [crd_pkg::VALUE_W-1:0] out_value
);

  logic                                        stalled;
  logic [crd_pkg::KIND_W+crd_pkg::VALUE_W-1:0] out_word;

  assign stalled  = out_valid && !out_ready;
  assign out_word = {out_kind, out_value};

  `CRD_ASSERT(a_out_hold, clk, rst_n, stalled |=> out_valid, "result dropped while stalled")
  `CRD_ASSERT(a_out_stable, clk, rst_n, stalled |=> $stable(out_word), "stalled result changed")
  `CRD_ASSERT(a_ready_free, clk, rst_n, !stalled |-> in_ready, "input blocked, register free")
  `CRD_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind compact_record_decoder crd_checker u_crd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_kind  (out_chan.kind),
  .out_value (out_chan.value)
);

### sim/tb.sv
`timescale 1ns / 1ps
// Testbench for compact_record_decoder: random record streams, self-checking scoreboard
module tb;
  import crd_pkg::*;

  localparam int VB = VALUE_BYTES_DEF;
  localparam logic [63:0] ACC_MASK = (VB >= 8) ? {64{1'b1}} : ((64'd1 << (8 * VB)) - 64'd1);
  localparam int N_ITEMS = 550;
  localparam int CALM_FROM = 470;
  localparam int LONG_HOLD = 300;

  class record_scoreboard;
    logic [1:0]  stage;
    logic [7:0]  recs_left;
    logic [5:0]  payload_left;
    logic [1:0]  ftype;
    logic        last_field;
    logic [4:0]  int_len;
    logic [63:0] acc;
    res_t        pending_results[$];
    int          fails;

    function new();
      stage = PH_COUNT;
      recs_left = '0;
      payload_left = '0;
      ftype = FT_STRING;
      last_field = 1'b0;
      int_len = '0;
      acc = '0;
      fails = 0;
    endfunction

    function res_t mk(logic [KIND_W-1:0] k, logic [VALUE_W-1:0] v, logic fd, logic rd,
                      logic sd);
      res_t r;
      r.kind = k;
      r.value = v;
      r.field_done = fd;
      r.record_done = rd;
      r.stream_done = sd;
      return r;
    endfunction

    // field complete: advance record and stream bookkeeping
    function res_t close_field(logic [KIND_W-1:0] k, logic [VALUE_W-1:0] v);
      logic rd, sd;
      rd = 1'b0;
      sd = 1'b0;
      stage = PH_HEADER;
      if (last_field) begin
        rd = 1'b1;
        recs_left = recs_left - 8'd1;
        if (recs_left == 8'd0) begin
          sd = 1'b1;
          stage = PH_COUNT;
        end
      end
      return mk(k, v, 1'b1, rd, sd);
    endfunction

    function void note_byte(logic [7:0] b);
      res_t r;
      logic hit;
      logic [63:0] v;
      int top;
      hit = 1'b1;
      r = '0;
      case (stage)
        PH_HEADER: begin
          last_field = b[7];
          if (b[6]) begin
            ftype = FT_STRING;
            if (b[5:0] == 6'd0) begin
              r = close_field(KIND_STR_START, '0);
            end else begin
              payload_left = b[5:0];
              stage = PH_PAYLOAD;
              r = mk(KIND_STR_START, VALUE_W'(b[5:0]), 1'b0, 1'b0, 1'b0);
            end
          end else begin
            ftype = b[5] ? FT_SIGNED : FT_UNSIGNED;
            int_len = b[4:0];
            acc = '0;
            if (int_len == 5'd0) begin
              r = close_field(b[5] ? KIND_SINT : KIND_UINT, '0);
            end else begin
              payload_left = {1'b0, int_len};
              stage = PH_PAYLOAD;
              hit = 1'b0;
            end
          end
        end
        PH_PAYLOAD: begin
          payload_left = payload_left - 6'd1;
          if (ftype == FT_STRING) begin
            if (payload_left == 6'd0) r = close_field(KIND_STR_CHAR, VALUE_W'(b));
            else r = mk(KIND_STR_CHAR, VALUE_W'(b), 1'b0, 1'b0, 1'b0);
          end else begin
            acc = ((acc << 8) | 64'(b)) & ACC_MASK;
            if (payload_left != 6'd0) begin
              hit = 1'b0;
            end else begin
              v = acc;
              // short signed values extend from their top byte
              if (ftype == FT_SIGNED && int_len >= 1 && int_len < VB && int_len < 8) begin
                top = 8 * int_len - 1;
                if (v[top]) v = v | ({64{1'b1}} << (top + 1));
              end
              r = close_field(ftype == FT_SIGNED ? KIND_SINT : KIND_UINT, v[VALUE_W-1:0]);
            end
          end
        end
        default: begin
          recs_left = b;
          if (b == 8'd0) begin
            stage = PH_COUNT;
            r = mk(KIND_COUNT, '0, 1'b0, 1'b0, 1'b1);
          end else begin
            stage = PH_HEADER;
            r = mk(KIND_COUNT, VALUE_W'(b), 1'b0, 1'b0, 1'b0);
          end
        end
      endcase
      if (hit) pending_results.push_back(r);
    endfunction

    function void check_result(res_t got);
      res_t e;
      if (pending_results.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("%0t: unexpected result kind=%0d value=%h fd=%b rd=%b sd=%b", $realtime,
                   got.kind, got.value, got.field_done, got.record_done, got.stream_done);
      end else begin
        e = pending_results.pop_front();
        if (got.kind !== e.kind || got.value !== e.value || got.field_done !== e.field_done ||
            got.record_done !== e.record_done || got.stream_done !== e.stream_done) begin
          fails++;
          if (fails <= 10)
            $display("%0t: mismatch exp kind=%0d value=%h fd=%b rd=%b sd=%b | got kind=%0d value=%h fd=%b rd=%b sd=%b",
                     $realtime, e.kind, e.value, e.field_done, e.record_done, e.stream_done,
                     got.kind, got.value, got.field_done, got.record_done, got.stream_done);
        end
      end
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   idle_on;
  bit   hold_req;
  int   n_sent;

  crd_byte_if   in_if();
  crd_result_if out_if();

  record_scoreboard sb = new();

  compact_record_decoder u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    res_t got;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        got.kind = out_if.kind;
        got.value = out_if.value;
        got.field_done = out_if.field_done;
        got.record_done = out_if.record_done;
        got.stream_done = out_if.stream_done;
        sb.check_result(got);
      end
      if (in_if.valid && in_if.ready) sb.note_byte(in_if.in_byte);
    end
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin
    int stall;
    stall = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall = LONG_HOLD;
      end
      if (stall > 0) begin
        stall--;
        out_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 6) == 0) begin
        stall = $urandom_range(1, 14) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.in_byte <= b;
    do @(posedge clk); while (!in_if.ready);
    n_sent++;
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  task automatic send_field(input bit last);
    int sel;
    int len;
    sel = $urandom_range(0, 2);
    if ($urandom_range(0, 15) == 0) len = $urandom_range(0, sel == 0 ? 63 : 31);
    else len = $urandom_range(0, 5);
    if (sel == 0) send_byte({last, 1'b1, 6'(len)});
    else send_byte({last, 1'b0, sel == 1, 5'(len)});
    repeat (len) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_stream();
    int mode;
    int nrec;
    int sent_rec;
    int nf;
    mode = $urandom_range(0, 19);
    if (mode < 2) begin
      // noise
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
    end else if (mode < 4) begin
      // abandoned stream: large count, only a few records
      send_byte(8'($urandom_range(5, 255)));
      sent_rec = $urandom_range(1, 2);
      repeat (sent_rec) begin
        nf = $urandom_range(1, 3);
        for (int f = 1; f <= nf; f++) send_field(f == nf);
      end
    end else if (mode == 4) begin
      send_byte(8'd0);
    end else begin
      nrec = $urandom_range(1, 4);
      send_byte(8'(nrec));
      repeat (nrec) begin
        nf = $urandom_range(1, 4);
        for (int f = 1; f <= nf; f++) send_field(f == nf);
      end
    end
  endtask

  initial begin
    logic [7:0] directed[$];
    bit held;
    bit drained;
    directed = '{8'h00, 8'h02, 8'h40, 8'h20, 8'h00, 8'h42, 8'h41, 8'h42, 8'h21, 8'h80,
                 8'h23, 8'h80, 8'h00, 8'h01, 8'h85, 8'hff, 8'h01, 8'h02, 8'h03, 8'h04,
                 8'ha4, 8'h80, 8'h00, 8'h00, 8'h00};
    held = 1'b0;
    drained = 1'b0;
    n_sent = 0;
    idle_on = 1'b1;
    hold_req = 1'b0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.in_byte = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_byte(directed[i]);
    drain_results();

    while (n_sent < N_ITEMS) begin
      if (n_sent >= CALM_FROM) idle_on = 1'b0;
      else idle_on = ($urandom_range(0, 9) < 7);
      if (!held && n_sent > 150) begin
        hold_req = 1'b1;
        held = 1'b1;
      end
      if (!drained && n_sent > 320) begin
        drain_results();
        drained = 1'b1;
      end
      send_stream();
    end

    in_if.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.fails == 0 && sb.outstanding() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
